// ===== sv/cpid_pkg.sv =====
// Shared types and constants for the clamped PID step unit.
package cpid_pkg;

  localparam int unsigned GAIN_W  = 32;
  localparam int unsigned LIMIT_W = 31;
  localparam int unsigned ERR_W   = 32;
  localparam int unsigned MOTOR_W = 16;
  localparam int unsigned REG_IDX_W = 3;

  typedef logic signed [GAIN_W-1:0] gain_t;
  typedef logic [LIMIT_W-1:0]       limit_t;
  typedef logic signed [ERR_W-1:0]  err_t;

  // Operation carried in the input tuser bit.
  typedef enum logic {
    CMD_STEP  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_KP_GAIN        = 3'd0,
    REG_KI_GAIN        = 3'd1,
    REG_KD_GAIN        = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_OUTPUT_LIMIT   = 3'd4
  } reg_idx_t;

endpackage

// ===== sv/cpid_mul_term.sv =====
// Registered gain multiply with a flooring shift by the fraction width.
module cpid_mul_term
  import cpid_pkg::*;
#(
  parameter int unsigned B_W       = 32,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned OUT_W     = 49
) (
  input  logic                    clk,
  input  logic                    en,
  input  gain_t                   gain,
  input  logic signed [B_W-1:0]   operand,
  output logic signed [OUT_W-1:0] term
);

  localparam int unsigned PROD_W = GAIN_W + B_W;

  logic signed [PROD_W-1:0] prod;

  // Dropping the low bits of a two's complement product rounds towards minus infinity.
  assign prod = gain * operand;

  always_ff @(posedge clk) begin
    if (en) begin
      term <= OUT_W'($signed(prod[PROD_W-1:FRAC_BITS]));
    end
  end

endmodule

// ===== sv/clamped_pid_step_unit.sv =====
// Top level of the clamped PID step unit: state update, product pipeline and output clamp.
//
//   Channel   Signals                          Beat contents (lowest bit first)
//   input     s_tvalid s_tready s_tdata s_tuser error_sample[31:0]; tuser: command
//   output    m_tvalid m_tready m_tdata        drive_value[31:0], motor_command[47:32]
//   config    cfg_wr_en cfg_index cfg_data     register index 0..4, 32-bit write data
//
// A beat passes four registers: the accumulator update and derivative difference, the three
// gain multipliers, the term adder, then the output clamp. It is valid on m_tvalid from the
// edge that loads the output register. One beat can be accepted in every cycle while
// m_tready does not hold the output. Each stage holds its beat only while the stage after
// it is full, so bubbles collapse and input beats are still taken while a finished result
// waits on m_tready, until the three earlier stages are full.
// rst is synchronous and clears the gains, limits, both state registers and all valid flags.
module clamped_pid_step_unit
  import cpid_pkg::*;
#(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned MOTOR_LIMIT = 32767
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration writes.
  input  logic                 cfg_wr_en,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  // Input stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [ERR_W-1:0]     s_tdata,   // error_sample[31:0]
  input  logic                 s_tuser,   // command[0]
  // Output stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [47:0]          m_tdata    // drive_value[31:0], motor_command[47:32]
);

  // Each floored product keeps all of its significant bits; the derivative product is
  // the widest at 32 by 33 bits.
  localparam int unsigned DIFF_W = ERR_W + 1;
  localparam int unsigned TERM_W = GAIN_W + DIFF_W - FRAC_BITS;
  localparam int unsigned SUM_W  = TERM_W + 2;

  localparam logic signed [ERR_W-1:0] MOTOR_HI = ERR_W'(MOTOR_LIMIT);
  localparam logic signed [ERR_W-1:0] MOTOR_LO = -ERR_W'(MOTOR_LIMIT);

  // Configuration registers.
  gain_t  kp_gain;
  gain_t  ki_gain;
  gain_t  kd_gain;
  limit_t integral_limit;
  limit_t output_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain        <= '0;
      ki_gain        <= '0;
      kd_gain        <= '0;
      integral_limit <= '0;
      output_limit   <= '0;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_KP_GAIN:        kp_gain        <= cfg_data;
        REG_KI_GAIN:        ki_gain        <= cfg_data;
        REG_KD_GAIN:        kd_gain        <= cfg_data;
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[LIMIT_W-1:0];
        REG_OUTPUT_LIMIT:   output_limit   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshake: a stage loads when its source is valid and it is empty or emptying.
  logic accept;
  logic v1, v2, v3;
  logic load2, load3, load_out;

  assign load_out = v3 && (!m_tvalid || m_tready);
  assign load3    = v2 && (!v3 || load_out);
  assign load2    = v1 && (!v2 || load3);
  assign s_tready = !v1 || load2;
  assign accept   = s_tvalid && s_tready;

  // Controller state and the accumulator update for the beat being accepted.
  err_t error_sum;
  err_t previous_error;

  err_t                     e_in;
  logic signed [ERR_W:0]    sum_wide;
  err_t                     sum_sat;
  err_t                     sum_next;
  err_t                     ilim;
  logic signed [DIFF_W-1:0] diff_in;
  logic                     is_clear;

  assign e_in     = s_tdata;
  assign is_clear = (cmd_t'(s_tuser) == CMD_CLEAR);
  assign ilim     = $signed({1'b0, integral_limit});
  assign diff_in  = DIFF_W'(e_in) - DIFF_W'(previous_error);

  always_comb begin
    sum_wide = (ERR_W+1)'(error_sum) + (ERR_W+1)'(e_in);
    // Saturate to the 32-bit range first, then clamp to the integral bound.
    if (sum_wide[ERR_W] != sum_wide[ERR_W-1]) begin
      sum_sat = sum_wide[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[ERR_W-1:0];
    end
    if (sum_sat > ilim) begin
      sum_next = ilim;
    end else if (sum_sat < -ilim) begin
      sum_next = -ilim;
    end else begin
      sum_next = sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (accept) begin
      if (is_clear) begin
        error_sum      <= '0;
        previous_error <= '0;
      end else begin
        // The previous error is replaced only after the difference above has used it.
        error_sum      <= sum_next;
        previous_error <= e_in;
      end
    end
  end

  // Stage 1: multiplier operands. A clear beat carries zero operands, so it yields a zero
  // drive value and a zero motor command further down.
  err_t                     e1;
  err_t                     sum1;
  logic signed [DIFF_W-1:0] diff1;

  always_ff @(posedge clk) begin
    if (accept) begin
      e1    <= is_clear ? '0 : e_in;
      sum1  <= is_clear ? '0 : sum_next;
      diff1 <= is_clear ? '0 : diff_in;
    end
  end

  // Stage 2: the three products, each registered.
  logic signed [TERM_W-1:0] p_term;
  logic signed [TERM_W-1:0] i_term;
  logic signed [TERM_W-1:0] d_term;

  cpid_mul_term #(.B_W(ERR_W), .FRAC_BITS(FRAC_BITS), .OUT_W(TERM_W)) u_p_term (
    .clk(clk), .en(load2), .gain(kp_gain), .operand(e1), .term(p_term)
  );

  cpid_mul_term #(.B_W(ERR_W), .FRAC_BITS(FRAC_BITS), .OUT_W(TERM_W)) u_i_term (
    .clk(clk), .en(load2), .gain(ki_gain), .operand(sum1), .term(i_term)
  );

  cpid_mul_term #(.B_W(DIFF_W), .FRAC_BITS(FRAC_BITS), .OUT_W(TERM_W)) u_d_term (
    .clk(clk), .en(load2), .gain(kd_gain), .operand(diff1), .term(d_term)
  );

  // Stage 3: exact sum of the terms.
  logic signed [SUM_W-1:0] total;

  always_ff @(posedge clk) begin
    if (load3) begin
      total <= SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);
    end
  end

  // Output stage: clamp to the output bound, then derive the motor command by truncating
  // the fraction towards zero and saturating to the motor range.
  logic signed [SUM_W-1:0] olim;
  err_t                    drive;
  err_t                    motor_floor;
  err_t                    motor_trunc;
  err_t                    motor;
  logic                    frac_nz;

  assign olim = SUM_W'($signed({1'b0, output_limit}));

  always_comb begin
    if (total > olim) begin
      drive = olim[ERR_W-1:0];
    end else if (total < -olim) begin
      drive = -olim[ERR_W-1:0];
    end else begin
      drive = total[ERR_W-1:0];
    end
    motor_floor = drive >>> FRAC_BITS;
    frac_nz     = |drive[FRAC_BITS-1:0];
    // Flooring a negative value with a fraction lands one below truncation.
    motor_trunc = motor_floor + ERR_W'(drive[ERR_W-1] && frac_nz);
    if (motor_trunc > MOTOR_HI) begin
      motor = MOTOR_HI;
    end else if (motor_trunc < MOTOR_LO) begin
      motor = MOTOR_LO;
    end else begin
      motor = motor_trunc;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {motor[MOTOR_W-1:0], drive};
    end
  end

  // Valid flags for every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        v1 <= 1'b1;
      end else if (load2) begin
        v1 <= 1'b0;
      end
      if (load2) begin
        v2 <= 1'b1;
      end else if (load3) begin
        v2 <= 1'b0;
      end
      if (load3) begin
        v3 <= 1'b1;
      end else if (load_out) begin
        v3 <= 1'b0;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A clear beat leaves both state registers at zero.
  assert property (@(posedge clk) disable iff (rst)
    accept && is_clear |=> error_sum == '0 && previous_error == '0)
    else $error("state not cleared after a clear beat");

  // A step beat is remembered as the previous error for the next derivative.
  assert property (@(posedge clk) disable iff (rst)
    accept && !is_clear |=> previous_error == $past(e_in))
    else $error("previous error not updated from the accepted beat");

  // The motor command never leaves the motor range.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[47:32]) <= $signed(MOTOR_HI[MOTOR_W-1:0])
              && $signed(m_tdata[47:32]) >= $signed(MOTOR_LO[MOTOR_W-1:0]))
    else $error("motor command outside the motor range");

  // A beat in the output register always lies within the output bound.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[31:0]) <= $signed({1'b0, output_limit})
              && $signed(m_tdata[31:0]) >= -$signed({1'b0, output_limit}))
    else $error("drive value outside the output bound");
`endif

endmodule

// ===== test/tb_clamped_pid_step_unit.sv =====
// Self-checking stream testbench for the clamped PID step unit.
`timescale 1ns / 1ps

module tb_clamped_pid_step_unit;
  import cpid_pkg::*;

  localparam int unsigned FRAC      = 16;
  localparam int unsigned MOTOR_MAX = 32767;

  // Saturation bounds of the 32-bit error accumulator.
  localparam longint ACC_MAX = 64'sd2147483647;
  localparam longint ACC_MIN = -64'sd2147483648;

  // Idling schemes: which side holds off, and how often, as a percentage.
  localparam int unsigned IDLE_SEND_LIGHT = 0;
  localparam int unsigned IDLE_RECV_LIGHT = 1;
  localparam int unsigned IDLE_NONE       = 2;

  // One input beat: the command travels on tuser and the error sample on tdata.
  typedef struct packed {
    cmd_t cmd;
    err_t err;
  } pid_item_t;

  // One expected output beat: the drive value and motor command to be seen on m_tdata.
  typedef struct packed {
    err_t               drive;
    logic signed [15:0] motor;
  } pid_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_wr_en = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]    cfg_data  = '0;

  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [ERR_W-1:0] s_tdata  = '0;   // error_sample[31:0]
  logic             s_tuser  = 1'b0; // command[0]

  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;              // drive_value[31:0], motor_command[47:32]

  clamped_pid_step_unit #(
    .FRAC_BITS  (FRAC),
    .MOTOR_LIMIT(MOTOR_MAX)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the configuration, kept wide so that the products never wrap.
  longint kp_q = 0;
  longint ki_q = 0;
  longint kd_q = 0;
  longint integ_lim_q = 0;
  longint out_lim_q = 0;

  // Shadow copy of the controller state.
  longint err_acc = 0;
  longint last_err = 0;

  pid_item_t   step_queue[$];  // beats waiting to be offered on the input
  pid_result_t drive_log[$];   // predicted output beats, oldest first
  pid_item_t   offered_item;   // the beat currently held on the input

  int          items_queued = 0;
  int          results_seen = 0;
  int          mismatches   = 0;
  int unsigned idle_mode    = IDLE_SEND_LIGHT;

  // Works out the result of one step and advances the shadow state. Each product is
  // floored after the shift, the three terms are summed exactly and only then clamped.
  function automatic pid_result_t pid_predict(pid_item_t it);
    longint      e;
    longint      sum;
    longint      p_term;
    longint      i_term;
    longint      d_term;
    longint      drv;
    longint      mot;
    pid_result_t r;
    if (it.cmd == CMD_CLEAR) begin
      err_acc  = 0;
      last_err = 0;
      r.drive  = '0;
      r.motor  = '0;
      return r;
    end
    e   = longint'(it.err);
    sum = err_acc + e;
    // The accumulator saturates to 32 bits first, then the anti-windup bound applies.
    if (sum > ACC_MAX) sum = ACC_MAX;
    if (sum < ACC_MIN) sum = ACC_MIN;
    if (sum > integ_lim_q) sum = integ_lim_q;
    if (sum < -integ_lim_q) sum = -integ_lim_q;
    err_acc = sum;
    p_term = (kp_q * e) >>> FRAC;
    i_term = (ki_q * sum) >>> FRAC;
    // The difference uses the previous error before that is replaced.
    d_term = (kd_q * (e - last_err)) >>> FRAC;
    last_err = e;
    drv = p_term + i_term + d_term;
    if (drv > out_lim_q) drv = out_lim_q;
    if (drv < -out_lim_q) drv = -out_lim_q;
    // The motor command truncates towards zero, unlike the product shifts.
    if (drv >= 0) mot = drv >>> FRAC;
    else mot = -((-drv) >>> FRAC);
    if (mot > longint'(MOTOR_MAX)) mot = MOTOR_MAX;
    if (mot < -longint'(MOTOR_MAX)) mot = -longint'(MOTOR_MAX);
    r.drive = drv[31:0];
    r.motor = mot[15:0];
    return r;
  endfunction

  function automatic int unsigned send_idle_pct();
    case (idle_mode)
      IDLE_SEND_LIGHT: return 33;
      IDLE_RECV_LIGHT: return 66;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_idle_pct();
    case (idle_mode)
      IDLE_SEND_LIGHT: return 66;
      IDLE_RECV_LIGHT: return 33;
      default: return 0;
    endcase
  endfunction

  // Input driver. The prediction is made when a beat is accepted, so that it sees the
  // shadow state exactly as the block does. A held beat is only replaced once taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        drive_log.push_back(pid_predict(offered_item));
      end
      if (!s_tvalid || s_tready) begin
        if (step_queue.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          offered_item = step_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= offered_item.err;
          s_tuser  <= offered_item.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: every accepted beat is checked against the oldest prediction.
  always @(posedge clk) begin
    pid_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (drive_log.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected output beat: drive %0d motor %0d",
                     $signed(m_tdata[31:0]), $signed(m_tdata[47:32]));
          mismatches++;
        end else begin
          want = drive_log.pop_front();
          if (m_tdata[31:0] !== want.drive || m_tdata[47:32] !== want.motor) begin
            if (mismatches < 10)
              $display("output mismatch: expected drive %0d motor %0d, got drive %0d motor %0d",
                       want.drive, want.motor,
                       $signed(m_tdata[31:0]), $signed(m_tdata[47:32]));
            mismatches++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  // One register write. The shadow is updated at once, which is safe because writes
  // only happen while the pipeline is empty.
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_KP_GAIN:        kp_q = longint'($signed(val));
      REG_KI_GAIN:        ki_q = longint'($signed(val));
      REG_KD_GAIN:        kd_q = longint'($signed(val));
      REG_INTEGRAL_LIMIT: integ_lim_q = longint'({33'd0, val[30:0]});
      REG_OUTPUT_LIMIT:   out_lim_q = longint'({33'd0, val[30:0]});
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_settings(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                               logic [31:0] integ_lim, logic [31:0] out_lim);
    write_reg(REG_KP_GAIN, kp);
    write_reg(REG_KI_GAIN, ki);
    write_reg(REG_KD_GAIN, kd);
    write_reg(REG_INTEGRAL_LIMIT, integ_lim);
    write_reg(REG_OUTPUT_LIMIT, out_lim);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_item(cmd_t cmd, logic [31:0] err);
    pid_item_t it;
    it.cmd = cmd;
    it.err = err;
    step_queue.push_back(it);
    items_queued++;
  endtask

  // Holds the sender back until every result has come out, then lets the four-stage
  // pipeline settle before the configuration may change.
  task automatic drain();
    while (results_seen != items_queued) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Errors lean towards small Q16.16 values, with the extremes and full-range noise mixed in.
  function automatic logic [31:0] rand_error();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      1, 2, 3, 4: return 32'(int'($urandom_range(2097152)) - 1048576);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4, 5, 6: return 32'(int'($urandom_range(1048576)) - 524288);
      default: return $urandom();
    endcase
  endfunction

  // Bit 31 of a limit write is ignored by the block, so it is set at random as well.
  function automatic logic [31:0] rand_limit();
    logic [30:0] lim;
    case ($urandom_range(9))
      0: lim = '0;
      1: lim = '1;
      2, 3, 4, 5: lim = 31'($urandom_range(1 << 24));
      default: lim = 31'($urandom());
    endcase
    return {1'($urandom_range(1)), lim};
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Gains of one, a half and two with open limits: sign extremes, accumulator saturation in both
    // directions and clears between the runs.
    load_settings(32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    push_item(CMD_STEP, 32'h0);
    push_item(CMD_STEP, 32'h1);
    push_item(CMD_STEP, 32'hffff_ffff);
    repeat (3) push_item(CMD_STEP, 32'h7fff_ffff);
    push_item(CMD_CLEAR, 32'h7fff_ffff);
    repeat (3) push_item(CMD_STEP, 32'h8000_0000);
    push_item(CMD_CLEAR, 32'h0);
    push_item(CMD_STEP, 32'h0001_0000);
    push_item(CMD_STEP, 32'hffff_0000);
    drain();

    // Zero limits hold both the accumulator and the output at zero, whatever the gains.
    load_settings(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h8000_0000);
    push_item(CMD_STEP, 32'h1234_5678);
    push_item(CMD_STEP, 32'h8000_0000);
    push_item(CMD_STEP, 32'h7fff_ffff);
    push_item(CMD_CLEAR, 32'h0);
    drain();

    // Extreme gains against a tight integral bound: the motor command saturates.
    load_settings(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0005_0000, 32'h7fff_ffff);
    push_item(CMD_STEP, 32'h7fff_ffff);
    push_item(CMD_STEP, 32'h8000_0000);
    push_item(CMD_STEP, 32'h0003_0000);
    push_item(CMD_STEP, 32'h0003_0000);
    push_item(CMD_STEP, 32'hffff_ffff);
    drain();

    // Random part: nine settings, three under each idling scheme, the first two at the
    // extremes. Each phase drains completely before the next setting is loaded.
    for (int phase = 0; phase < 9; phase++) begin
      idle_mode = (phase < 3) ? IDLE_SEND_LIGHT : (phase < 6) ? IDLE_RECV_LIGHT : IDLE_NONE;
      if (phase == 0)
        load_settings(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h7fff_ffff);
      else if (phase == 1)
        load_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff,
                      32'h0000_0001);
      else
        load_settings(rand_gain(), rand_gain(), rand_gain(), rand_limit(), rand_limit());
      for (int n = 0; n < 92; n++) begin
        push_item(($urandom_range(15) == 0) ? CMD_CLEAR : CMD_STEP, rand_error());
      end
      drain();
    end

    if (mismatches == 0 && drive_log.size() == 0) begin
      $display("[clamped_pid_step_unit] OK");
    end else begin
      $display("[clamped_pid_step_unit] ERROR");
    end
    $finish;
  end

  // Far beyond the slowest correct run; reaching this means the block has stalled.
  initial begin
    #5_000_000;
    $display("[clamped_pid_step_unit] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cpid_pkg.sv
sv/cpid_mul_term.sv
sv/clamped_pid_step_unit.sv
test/tb_clamped_pid_step_unit.sv
